// ----- src/rmap_pkg.sv -----
// Package: shared types, codes and CRC function for the RMAP header parser.
`timescale 1ns / 1ps
package rmap_pkg;

   localparam int PosWidth = 26;
   localparam logic [PosWidth-1:0] PosMax = {PosWidth{1'b1}};

   localparam logic [7:0] PathLimit = 8'h20;
   localparam logic [7:0] ProtocolId = 8'h01;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_INCOMPLETE = 3'd1,
      STATUS_HEADER_CRC = 3'd2,
      STATUS_PROTOCOL   = 3'd3,
      STATUS_INVALID    = 3'd4,
      STATUS_DATA_CRC   = 3'd5
   } status_type;

   typedef enum logic {
      KIND_DATA    = 1'b0,
      KIND_SUMMARY = 1'b1
   } result_kind_type;

   // One result beat, highest field first; payload_byte is lowest in tdata.
   typedef struct packed {
      logic [23:0] length_field;
      logic [31:0] memory_addr;
      logic [7:0]  extended_addr;
      logic [15:0] transaction_number;
      logic [7:0]  initiator_logical;
      logic [7:0]  target_logical;
      logic [7:0]  key_or_status;
      logic [7:0]  instruction_byte;
      logic [2:0]  parse_status;
      logic [1:0]  packet_kind;
      logic [7:0]  payload_byte;
   } result_type;

   // Byte-wide RMAP CRC-8 step, reflected polynomial 0xE0.
   function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ 8'hE0) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- src/rmap_packet_header_parser.sv -----
// Top level: RMAP packet header parser, one byte per beat.
//
//   channel | ports     | dir | beat content
//   --------+-----------+-----+-------------------------------------------
//   input   | req_*     | in  | packet byte, end mark on tlast
//   result  | rsp_*     | out | payload byte or end-of-packet summary
//
// A byte is taken every cycle that req_tready is high; the per-byte CRC and
// field capture sit between the packet state and result registers, so a
// result appears in the cycle after its byte. The result register holds its
// beat while rsp_tready is low, and req_tready follows it so that a new
// byte is taken whenever the result slot is empty or drains that cycle.
// Synchronous active-high reset returns to the path skipping phase.
`timescale 1ns / 1ps
module rmap_packet_header_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // packet_byte[7:0]
   input  logic         req_tlast,   // end_of_packet
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // payload_byte, packet_kind, parse_status,
                                     // instruction_byte, key_or_status,
                                     // target_logical, initiator_logical,
                                     // transaction_number, extended_addr,
                                     // memory_addr, length_field, zero fill
   output logic         rsp_tuser    // result_kind
);

   logic                          in_packet_ff, in_packet_in;
   logic [rmap_pkg::PosWidth-1:0] pos_ff, pos_in;
   logic [7:0]  hcrc_ff, hcrc_in, dcrc_ff, dcrc_in;
   logic [7:0]  first_ff, first_in, proto_ff, proto_in, instr_ff, instr_in;
   logic [7:0]  key_ff, key_in, b4_ff, b4_in, tidh_ff, tidh_in, tidl_ff, tidl_in;
   logic [7:0]  ext_ff, ext_in;
   logic [31:0] addr_ff, addr_in;
   logic [23:0] len_ff, len_in;
   logic        bad_ff, bad_in;

   logic                  out_valid_ff, out_valid_in;
   logic                  out_kind_ff, out_kind_in;
   rmap_pkg::result_type  out_ff, out_in;

   logic accept;
   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {3'b000, out_ff};

   function automatic logic instr_bad(input logic [7:0] ins);
      return ins[7] || (!ins[5] && (ins[4] || !ins[3])) || (!ins[6] && ins[5] && !ins[3]);
   endfunction

   function automatic logic [4:0] header_len(input logic [7:0] ins);
      if (ins[6]) return 5'd16 + {1'b0, ins[1:0], 2'b00};
      return ins[5] ? 5'd8 : 5'd12;
   endfunction

   // Per-byte parse and result build.
   always_comb begin
      logic [7:0]  b, ins;
      logic        cmd, wr, has_data, eop, skip, bad_now, len_ok;
      logic [4:0]  h, ra;
      logic [rmap_pkg::PosWidth-1:0] pos, rel;
      logic [rmap_pkg::PosWidth:0]   total;
      logic [2:0]  status;

      b = req_tdata;
      eop = req_tlast;
      in_packet_in = in_packet_ff; pos_in = pos_ff; hcrc_in = hcrc_ff; dcrc_in = dcrc_ff;
      first_in = first_ff; proto_in = proto_ff; instr_in = instr_ff; key_in = key_ff;
      b4_in = b4_ff; tidh_in = tidh_ff; tidl_in = tidl_ff; ext_in = ext_ff;
      addr_in = addr_ff; len_in = len_ff; bad_in = bad_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_kind_in = out_kind_ff;
      out_in = out_ff;

      skip = !in_packet_ff && (b < rmap_pkg::PathLimit);
      pos = pos_ff;
      if (!skip) begin
         in_packet_in = 1'b1;
         if (pos_ff != rmap_pkg::PosMax) pos_in = pos_ff + 1'b1;
         if (pos == 0) first_in = b;
         if (pos == 1) proto_in = b;
         if (pos == 3) key_in = b;
      end
      bad_now = bad_ff;
      ins = instr_ff;
      if (!skip && pos == 2) begin
         ins = b;
         instr_in = b;
         if (instr_bad(b)) begin
            bad_now = 1'b1;
         end
      end
      bad_in = bad_now;
      cmd = ins[6];
      wr = ins[5];
      h = header_len(ins);
      has_data = cmd == wr;
      ra = cmd ? {1'b0, ins[1:0], 2'b00} : 5'd0;
      rel = pos - {{(rmap_pkg::PosWidth-5){1'b0}}, ra};

      if (!skip) begin
         if (pos < {{(rmap_pkg::PosWidth-5){1'b0}}, h}) begin
            hcrc_in = rmap_pkg::crc_step(hcrc_ff, b);
            if (pos >= 4 && pos >= 4 + {{(rmap_pkg::PosWidth-5){1'b0}}, ra}) begin
               if (rel == 4) b4_in = b;
               else if (rel == 5) tidh_in = b;
               else if (rel == 6) tidl_in = b;
               else if (rel == 7) ext_in = b;
               else if (rel <= 11) begin
                  if (cmd) addr_in = {addr_ff[23:0], b};
                  else if (rel <= 10) len_in = {len_ff[15:0], b};
               end else if (rel <= 14 && cmd) len_in = {len_ff[15:0], b};
            end
         end else begin
            dcrc_in = rmap_pkg::crc_step(dcrc_ff, b);
            if (!eop && !bad_now && has_data &&
                (pos - {{(rmap_pkg::PosWidth-5){1'b0}}, h}) <
                {{(rmap_pkg::PosWidth-24){1'b0}}, len_ff}) begin
               out_valid_in = 1'b1;
               out_kind_in = rmap_pkg::KIND_DATA;
               out_in = '0;
               out_in.payload_byte = b;
            end
         end
      end

      // Summary on the end byte, from the updated state.
      total = {1'b0, {{(rmap_pkg::PosWidth-5){1'b0}}, h}} +
              {{(rmap_pkg::PosWidth-23){1'b0}}, len_in} + 1'b1;
      len_ok = {1'b0, pos_in} == total;
      if (pos_in < 4) status = rmap_pkg::STATUS_INCOMPLETE;
      else if (bad_in) status = rmap_pkg::STATUS_INVALID;
      else if (cmd && !wr && pos_in != {{(rmap_pkg::PosWidth-5){1'b0}}, h})
         status = rmap_pkg::STATUS_INCOMPLETE;
      else if (cmd && wr && pos_in <= {{(rmap_pkg::PosWidth-5){1'b0}}, h})
         status = rmap_pkg::STATUS_INCOMPLETE;
      else if (!cmd && wr && pos_in != {{(rmap_pkg::PosWidth-5){1'b0}}, h})
         status = rmap_pkg::STATUS_INCOMPLETE;
      else if (!cmd && !wr && pos_in < {{(rmap_pkg::PosWidth-5){1'b0}}, h})
         status = rmap_pkg::STATUS_INCOMPLETE;
      else if (hcrc_in != 8'h00) status = rmap_pkg::STATUS_HEADER_CRC;
      else if (proto_in != rmap_pkg::ProtocolId) status = rmap_pkg::STATUS_PROTOCOL;
      else if (!cmd && !wr && ext_in != 8'h00) status = rmap_pkg::STATUS_INVALID;
      else if (has_data && !len_ok) status = rmap_pkg::STATUS_INCOMPLETE;
      else if (has_data && dcrc_in != 8'h00) status = rmap_pkg::STATUS_DATA_CRC;
      else status = rmap_pkg::STATUS_OK;

      if (eop) begin
         out_valid_in = 1'b1;
         out_kind_in = rmap_pkg::KIND_SUMMARY;
         out_in.payload_byte = 8'h00;
         out_in.packet_kind = {instr_in[6], instr_in[5]};
         out_in.parse_status = status;
         out_in.instruction_byte = instr_in;
         out_in.key_or_status = key_in;
         out_in.target_logical = instr_in[6] ? first_in : b4_in;
         out_in.initiator_logical = instr_in[6] ? b4_in : first_in;
         out_in.transaction_number = {tidh_in, tidl_in};
         out_in.extended_addr = instr_in[6] ? ext_in : 8'h00;
         out_in.memory_addr = instr_in[6] ? addr_in : 32'h0;
         out_in.length_field = len_in;
         // Clear packet state for the next packet.
         in_packet_in = 1'b0; pos_in = '0; hcrc_in = '0; dcrc_in = '0;
         first_in = '0; proto_in = '0; instr_in = '0; key_in = '0; b4_in = '0;
         tidh_in = '0; tidl_in = '0; ext_in = '0; addr_in = '0; len_in = '0;
         bad_in = 1'b0;
      end
   end

   // Advance packet state on an accepted beat; drain the result slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff <= 1'b0; pos_ff <= '0; hcrc_ff <= '0; dcrc_ff <= '0;
         first_ff <= '0; proto_ff <= '0; instr_ff <= '0; key_ff <= '0; b4_ff <= '0;
         tidh_ff <= '0; tidl_ff <= '0; ext_ff <= '0; addr_ff <= '0; len_ff <= '0;
         bad_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (accept) begin
         in_packet_ff <= in_packet_in; pos_ff <= pos_in; hcrc_ff <= hcrc_in;
         dcrc_ff <= dcrc_in; first_ff <= first_in; proto_ff <= proto_in;
         instr_ff <= instr_in; key_ff <= key_in; b4_ff <= b4_in; tidh_ff <= tidh_in;
         tidl_ff <= tidl_in; ext_ff <= ext_in; addr_ff <= addr_in; len_ff <= len_in;
         bad_ff <= bad_in;
         out_valid_ff <= out_valid_in;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Result payload: load only with a new beat.
   always_ff @(posedge clock) begin
      if (accept && out_valid_in && !(out_valid_ff && !rsp_tready)) begin
         out_ff <= out_in;
         out_kind_ff <= out_kind_in;
      end
   end

endmodule
